@@ hw/rtl/gacr_pkg.sv @@
// ----------------------------------------------------------------------------
// gacr_pkg
// Shared types and codes for the glyph atlas cell replacement block.
// ----------------------------------------------------------------------------
package gacr_pkg;

    // Fixed field widths of the request and response
    localparam int CMD_W    = 2;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int COLUMN_W = 4;
    localparam int ROW_W    = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TAG_W-1:0] glyph_tag;
    } gacr_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  cell_index;
        logic [COLUMN_W-1:0] cell_column;
        logic [ROW_W-1:0]    cell_row;
        logic                evicted_valid;
        logic [TAG_W-1:0]    evicted_tag;
    } gacr_rsp_t;

endpackage

@@ hw/rtl/gacr_cell_counter.sv @@
// ----------------------------------------------------------------------------
// gacr_cell_counter
// Wrapping cell counter that tracks the cell index together with its grid
// column and row, so no division is needed to split an index.
// ----------------------------------------------------------------------------
module gacr_cell_counter
    import gacr_pkg::*;
#(
    parameter int CELLS        = 128,
    parameter int GRID_COLUMNS = 16,
    parameter int IDX_W        = 7,
    parameter int COL_W        = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             step,
    output logic [IDX_W-1:0] idx,
    output logic [COL_W-1:0] col,
    output logic [IDX_W-1:0] row
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLUMNS - 1);

    logic [IDX_W-1:0] idx_reg;
    logic [COL_W-1:0] col_reg;
    logic [IDX_W-1:0] row_reg;

    // Advance one cell, wrapping to cell zero after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (clear)
        begin
            idx_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            if (idx_reg == LAST_IDX)
            begin
                idx_reg <= '0;
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    assign idx = idx_reg;
    assign col = col_reg;
    assign row = row_reg;

endmodule

@@ hw/rtl/glyph_atlas_cell_replacement_core.sv @@
// ----------------------------------------------------------------------------
// glyph_atlas_cell_replacement_core
// Round-robin cell replacement for a glyph atlas, skipping cells in use this
// frame. One tag compare per cycle over a tag RAM, then a cursor scan.
// ----------------------------------------------------------------------------
//
//  channel | signals                  | moves
//  --------+--------------------------+---------------------------------------
//  req     | req_valid, req_stall, req| command and glyph tag, one request
//  rsp     | rsp_valid, rsp_stall, rsp| status, cell, evicted owner
//
//  Frame start, flush and unknown commands give no response.
//  A lookup compares its tag against the cells in order, one tag RAM read per
//  cycle; a miss then lets the cursor examine cells until one is free this
//  frame, and the request is dropped if every cell is used this frame.
//  Reset clears owner and used bits, the cursor and all control at once.
//  A stalled response waits in its output register; a new request is taken
//  meanwhile, and its response waits until that register frees up.
//
module glyph_atlas_cell_replacement_core
    import gacr_pkg::*;
#(
    parameter int CELLS        = 128,
    parameter int GRID_COLUMNS = 16,
    parameter int TAG_BITS     = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  gacr_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output gacr_rsp_t rsp
);

    localparam int IDX_W   = $clog2(CELLS);
    localparam int COL_W   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SCAN,
        S_EVICT,
        S_RESULT
    } state_t;

    state_t state_reg;

    // Tag RAM, read data registered
    logic [STORE_W-1:0] owner_mem [CELLS];
    logic [STORE_W-1:0] rdata_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [CELLS-1:0]   owner_valid_reg;
    logic [CELLS-1:0]   used_reg;

    logic [STORE_W-1:0] tag_reg;
    logic               issue_done_reg;
    logic               cmp_valid_reg;
    logic               cmp_last_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [COL_W-1:0]   cmp_col_reg;
    logic [IDX_W-1:0]   cmp_row_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic [COL_W-1:0]   pick_col_reg;
    logic [IDX_W-1:0]   pick_row_reg;
    gacr_rsp_t          res_reg;
    logic               rsp_valid_reg;
    gacr_rsp_t          rsp_reg;

    logic               accept;
    logic               issuing;
    logic               hit;
    logic               slot_free;

    logic [IDX_W-1:0]   srch_idx;
    logic [COL_W-1:0]   srch_col;
    logic [IDX_W-1:0]   srch_row;
    logic [IDX_W-1:0]   cur_idx;
    logic [COL_W-1:0]   cur_col;
    logic [IDX_W-1:0]   cur_row;

    // Pack one response
    function automatic gacr_rsp_t pack_rsp(
        input logic [STATUS_W-1:0] status,
        input logic [IDX_W-1:0]    idx,
        input logic [COL_W-1:0]    col,
        input logic [IDX_W-1:0]    row,
        input logic                ev_valid,
        input logic [TAG_W-1:0]    ev_tag
    );
        gacr_rsp_t r;
        r.status        = status;
        r.cell_index    = INDEX_W'(idx);
        r.cell_column   = COLUMN_W'(col);
        r.cell_row      = ROW_W'(row);
        r.evicted_valid = ev_valid;
        r.evicted_tag   = ev_tag;
        return r;
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign issuing   = (state_reg == S_SEARCH) && !issue_done_reg;
    assign hit       = cmp_valid_reg && owner_valid_reg[cmp_idx_reg]
                       && (rdata_reg == tag_reg);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // Search address walks cells 0..CELLS-1 for the tag compare
    gacr_cell_counter #(
        .CELLS        (CELLS),
        .GRID_COLUMNS (GRID_COLUMNS),
        .IDX_W        (IDX_W),
        .COL_W        (COL_W)
    ) u_search_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept && (req.cmd == CMD_LOOKUP)),
        .step  (issuing),
        .idx   (srch_idx),
        .col   (srch_col),
        .row   (srch_row)
    );

    // Persistent replacement cursor
    gacr_cell_counter #(
        .CELLS        (CELLS),
        .GRID_COLUMNS (GRID_COLUMNS),
        .IDX_W        (IDX_W),
        .COL_W        (COL_W)
    ) u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept && (req.cmd == CMD_FLUSH)),
        .step  (state_reg == S_SCAN),
        .idx   (cur_idx),
        .col   (cur_col),
        .row   (cur_row)
    );

    // RAM address select
    always_comb
    begin
        case (state_reg)
            S_SEARCH: rd_addr = srch_idx;
            S_SCAN:   rd_addr = cur_idx;
            default:  rd_addr = pick_idx_reg;
        endcase
    end

    // Tag RAM: one read and one write port
    always_ff @(posedge clk)
    begin
        rdata_reg <= owner_mem[rd_addr];
        if (state_reg == S_EVICT)
        begin
            owner_mem[pick_idx_reg] <= tag_reg;
        end
    end

    // Sequencer, cell flags and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            owner_valid_reg <= '0;
            used_reg        <= '0;
            tag_reg         <= '0;
            issue_done_reg  <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            cmp_last_reg    <= 1'b0;
            cmp_idx_reg     <= '0;
            cmp_col_reg     <= '0;
            cmp_row_reg     <= '0;
            scan_cnt_reg    <= '0;
            pick_idx_reg    <= '0;
            pick_col_reg    <= '0;
            pick_row_reg    <= '0;
            res_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            // Compare pipeline follows each issued read
            cmp_valid_reg <= issuing;
            cmp_last_reg  <= (srch_idx == LAST_IDX);
            cmp_idx_reg   <= srch_idx;
            cmp_col_reg   <= srch_col;
            cmp_row_reg   <= srch_row;

            // Response taken; a pending result reloads it in S_RESULT
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.cmd)
                            CMD_LOOKUP:
                            begin
                                tag_reg        <= STORE_W'(req.glyph_tag);
                                issue_done_reg <= 1'b0;
                                state_reg      <= S_SEARCH;
                            end
                            CMD_FRAME:
                            begin
                                used_reg <= '0;
                            end
                            CMD_FLUSH:
                            begin
                                owner_valid_reg <= '0;
                                used_reg        <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_SEARCH:
                begin
                    if (issuing && (srch_idx == LAST_IDX))
                    begin
                        issue_done_reg <= 1'b1;
                    end
                    if (hit)
                    begin
                        used_reg[cmp_idx_reg] <= 1'b1;
                        res_reg   <= pack_rsp(ST_HIT, cmp_idx_reg, cmp_col_reg,
                                              cmp_row_reg, 1'b0, '0);
                        state_reg <= S_RESULT;
                    end
                    else if (cmp_valid_reg && cmp_last_reg)
                    begin
                        scan_cnt_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                end

                // Cursor examines one cell per cycle
                S_SCAN:
                begin
                    if (!used_reg[cur_idx])
                    begin
                        pick_idx_reg <= cur_idx;
                        pick_col_reg <= cur_col;
                        pick_row_reg <= cur_row;
                        state_reg    <= S_EVICT;
                    end
                    else if (scan_cnt_reg == LAST_IDX)
                    begin
                        res_reg   <= pack_rsp(ST_DROPPED, '0, '0, '0, 1'b0, '0);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end

                // Old owner tag is in rdata_reg; install the new tag
                S_EVICT:
                begin
                    res_reg <= pack_rsp(ST_PLACED, pick_idx_reg, pick_col_reg,
                                        pick_row_reg, owner_valid_reg[pick_idx_reg],
                                        owner_valid_reg[pick_idx_reg]
                                        ? TAG_W'(rdata_reg) : '0);
                    owner_valid_reg[pick_idx_reg] <= 1'b1;
                    used_reg[pick_idx_reg]        <= 1'b1;
                    state_reg                     <= S_RESULT;
                end

                // Hand off once the output register is free
                S_RESULT:
                begin
                    if (slot_free)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/atlas_check_pkg.sv @@
// ----------------------------------------------------------------------------
// atlas_check_pkg
// Shadow copy of the glyph atlas: predicts the response to every accepted
// lookup request and checks the block's responses against them in order.
// ----------------------------------------------------------------------------
package atlas_check_pkg;

    import gacr_pkg::*;

    localparam int ATLAS_CELLS   = 128;
    localparam int ATLAS_COLUMNS = 16;

    class atlas_tracker;

        logic [TAG_W-1:0] owner_tag [ATLAS_CELLS];
        bit               owner_valid [ATLAS_CELLS];
        bit               used_now [ATLAS_CELLS];
        int               cursor;
        gacr_rsp_t        expected_cells [$];
        int               mismatches;

        function new();
            foreach (owner_valid[i])
            begin
                owner_tag[i]   = '0;
                owner_valid[i] = 1'b0;
                used_now[i]    = 1'b0;
            end
            cursor     = 0;
            mismatches = 0;
        endfunction

        // Cell number plus its grid position
        function gacr_rsp_t with_cell(gacr_rsp_t r, int idx);
            r.cell_index  = INDEX_W'(idx);
            r.cell_column = COLUMN_W'(idx % ATLAS_COLUMNS);
            r.cell_row    = ROW_W'(idx / ATLAS_COLUMNS);
            return r;
        endfunction

        // Tag search first, then a round-robin scan for a cell free this frame
        function gacr_rsp_t resolve_lookup(logic [TAG_W-1:0] tag);
            gacr_rsp_t res;
            int        slot;
            int        cand;
            int        pick;
            res = '0;
            for (slot = 0; slot < ATLAS_CELLS; slot++)
            begin
                if (owner_valid[slot] && owner_tag[slot] == tag)
                begin
                    used_now[slot] = 1'b1;
                    res.status     = ST_HIT;
                    return with_cell(res, slot);
                end
            end
            pick = -1;
            for (slot = 0; slot < ATLAS_CELLS && pick < 0; slot++)
            begin
                cand   = cursor;
                cursor = (cursor + 1) % ATLAS_CELLS;
                if (!used_now[cand])
                    pick = cand;
            end
            // every cell used this frame: cursor is back where it started
            if (pick < 0)
            begin
                res.status = ST_DROPPED;
                return res;
            end
            res.status = ST_PLACED;
            res        = with_cell(res, pick);
            if (owner_valid[pick])
            begin
                res.evicted_valid = 1'b1;
                res.evicted_tag   = owner_tag[pick];
            end
            owner_tag[pick]   = tag;
            owner_valid[pick] = 1'b1;
            used_now[pick]    = 1'b1;
            return res;
        endfunction

        // Called on each accepted request
        function void note_request(gacr_req_t r);
            case (r.cmd)
                CMD_LOOKUP: expected_cells.push_back(resolve_lookup(r.glyph_tag));
                CMD_FRAME:
                begin
                    foreach (used_now[i])
                        used_now[i] = 1'b0;
                end
                CMD_FLUSH:
                begin
                    foreach (used_now[i])
                    begin
                        used_now[i]    = 1'b0;
                        owner_valid[i] = 1'b0;
                    end
                    cursor = 0;
                end
                default: ;  // unknown command: no state change, no response
            endcase
        endfunction

        function void compare_field(string what, logic [TAG_W-1:0] want,
                                    logic [TAG_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
                mismatches++;
            end
        endfunction

        // Called on each accepted response
        function void check_response(gacr_rsp_t got);
            gacr_rsp_t want;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual status %0d cell %0d",
                         $time, got.status, got.cell_index);
                mismatches++;
                return;
            end
            want = expected_cells.pop_front();
            compare_field("status",        TAG_W'(want.status),        TAG_W'(got.status));
            compare_field("cell_index",    TAG_W'(want.cell_index),    TAG_W'(got.cell_index));
            compare_field("cell_column",   TAG_W'(want.cell_column),   TAG_W'(got.cell_column));
            compare_field("cell_row",      TAG_W'(want.cell_row),      TAG_W'(got.cell_row));
            compare_field("evicted_valid", TAG_W'(want.evicted_valid), TAG_W'(got.evicted_valid));
            compare_field("evicted_tag",   want.evicted_tag,           got.evicted_tag);
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

    endclass

endpackage

@@ tb/tb_glyph_atlas_cell_replacement_core.sv @@
// ----------------------------------------------------------------------------
// tb_glyph_atlas_cell_replacement_core
// Drives lookup, frame-start, flush and unknown requests with random gaps and
// response stalls, including one long response hold-off, and checks every
// response against the shadow atlas.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_cell_replacement_core;

    timeunit 1ns;
    timeprecision 1ps;

    import gacr_pkg::*;
    import atlas_check_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TARGET_ITEMS   = 750;
    localparam int POOL_SIZE      = 96;
    localparam int PRESSURE_HOLD  = 3000;
    localparam int DRAIN_CYCLES   = 300;    // longer than the slowest miss
    localparam int WATCHDOG_LIMIT = 20000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    gacr_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    gacr_rsp_t rsp;

    atlas_tracker tracker;
    int           responses_seen = 0;
    int           items_sent     = 0;
    int           issued_total   = 0;
    int           idle_cycles    = 0;
    bit           sender_gaps_on = 1'b1;
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    glyph_atlas_cell_replacement_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(input gacr_req_t r, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tracker.note_request(r);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag);
        gacr_req_t r;
        r.cmd       = cmd;
        r.glyph_tag = tag;
        send_request(r, sender_gaps_on ? pick_gap() : 0);
        if (cmd != CMD_UNUSED)
            items_sent++;
        issued_total++;
        // alternate stretches with and without sender gaps
        if (issued_total % 40 == 0)
            sender_gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    // New frame, then enough fresh tags to use every cell and overflow
    task automatic fill_frame();
        int n;
        int extra;
        extra = $urandom_range(1, 6);
        issue(CMD_FRAME, $urandom);
        for (n = 0; n < ATLAS_CELLS + extra; n++)
            issue(CMD_LOOKUP, $urandom);
        // pool tags were evicted by the fresh ones, so these lookups drop in the full frame
        for (n = 0; n < 4; n++)
            issue(CMD_LOOKUP, tag_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endtask

    // Repeated lookups over a small set of tags
    task automatic working_set();
        int base;
        int width;
        int n;
        int count;
        base  = $urandom_range(0, POOL_SIZE - 1);
        width = $urandom_range(2, 24);
        count = $urandom_range(15, 40);
        for (n = 0; n < count; n++)
            issue(CMD_LOOKUP, tag_pool[(base + $urandom_range(0, width - 1)) % POOL_SIZE]);
    endtask

    // New frame followed by a mix of fresh and pool tags; misses evict old owners
    task automatic frame_churn();
        int n;
        int count;
        count = $urandom_range(10, 30);
        issue(CMD_FRAME, $urandom);
        for (n = 0; n < count; n++)
            issue(CMD_LOOKUP, ($urandom_range(0, 1) != 0) ? $urandom
                                  : tag_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endtask

    // Any command, any tag
    task automatic noise();
        int n;
        int count;
        count = $urandom_range(3, 8);
        for (n = 0; n < count; n++)
            issue(CMD_W'($urandom_range(0, 3)), $urandom);
    endtask

    // Response side: random stalls plus one long hold-off
    initial
    begin : rsp_side
        int stall_run;
        int mode_left;
        bit pressure_done;
        bit stalls_on;
        stall_run     = 0;
        mode_left     = 0;
        pressure_done = 1'b0;
        stalls_on     = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && responses_seen >= 150)
            begin
                pressure_done = 1'b1;
                stall_run     = PRESSURE_HOLD;
            end
            if (mode_left == 0)
            begin
                stalls_on = ($urandom_range(0, 3) != 0);
                mode_left = $urandom_range(100, 600);
            end
            else
                mode_left--;
            if (stall_run > 0)
            begin
                rsp_stall <= 1'b1;
                stall_run--;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_run = pick_gap();
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Response check
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            tracker.check_response(rsp);
            responses_seen++;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int pick;
        tracker = new();
        for (i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = $urandom;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: tag extremes, hits, placements, unknown command,
        // frame start, flush of a populated table
        issue(CMD_LOOKUP, 32'h0000_0000);
        issue(CMD_LOOKUP, 32'h0000_0000);
        issue(CMD_LOOKUP, 32'hFFFF_FFFF);
        issue(CMD_LOOKUP, 32'hFFFF_FFFF);
        issue(CMD_UNUSED, 32'h0000_0000);
        issue(CMD_UNUSED, 32'hFFFF_FFFF);
        issue(CMD_LOOKUP, 32'h0000_0000);
        issue(CMD_FRAME,  32'hFFFF_FFFF);
        issue(CMD_LOOKUP, 32'h8000_0001);
        issue(CMD_LOOKUP, 32'h0000_0000);
        issue(CMD_LOOKUP, 32'h7FFF_FFFE);
        issue(CMD_FLUSH,  32'h0000_0000);
        issue(CMD_LOOKUP, 32'hFFFF_FFFF);
        issue(CMD_LOOKUP, 32'h0000_0000);
        issue(CMD_LOOKUP, 32'h7FFF_FFFE);
        issue(CMD_FRAME,  32'h0000_0000);
        issue(CMD_LOOKUP, 32'h5A5A_A5A5);
        issue(CMD_LOOKUP, 32'hA5A5_5A5A);
        issue(CMD_LOOKUP, 32'h5A5A_A5A5);
        issue(CMD_FLUSH,  32'hFFFF_FFFF);
        issue(CMD_LOOKUP, 32'h0000_0001);
        issue(CMD_LOOKUP, 32'h8000_0000);

        // Random: start with a full frame so eviction and drops show up early
        fill_frame();
        while (items_sent < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                fill_frame();
            else if (pick < 55)
                working_set();
            else if (pick < 80)
                frame_churn();
            else
                noise();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
